[hdl/dtq_pkg.sv]
package dtq_pkg;

  // Clock and deadline width
  localparam int CLK_W = 40;
  // Slot field width and the largest table it can address
  localparam int SLOT_W = 4;
  localparam int MAX_SLOTS = 16;
  localparam int NUM_TIMERS_DEF = 16;

  // func codes
  localparam logic [1:0] FN_ADD  = 2'd0;
  localparam logic [1:0] FN_DEL  = 2'd1;
  localparam logic [1:0] FN_TICK = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ADD_ARMED = 2'd1;
  localparam logic [1:0] ST_DEL_IDLE  = 2'd2;

  typedef struct packed {
    logic [1:0]        func;
    logic [SLOT_W-1:0] slot_id;
    logic [31:0]       timeout_ms;
  } req_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              expired;
    logic [SLOT_W-1:0] expired_slot;
    logic              none_pending;
    logic [31:0]       remaining_ms;
    logic              last;
  } rsp_item_t;

endpackage

[hdl/deadline_timer_queue_top.sv]
// Channel | dir | handshake            | payload
// --------+-----+----------------------+------------------------------------
// req     | in  | req_valid/req_ready  | req_item_t: func, slot_id, timeout_ms
// rsp     | out | rsp_valid/rsp_ready  | rsp_item_t: status .. last
//
// Sequencing: S = min(NUM_TIMERS, 16) slots. Add, delete and unused func run
// a MIN scan of the S slots, then FIN and EMIT; a tick first runs a MARK scan,
// and with slots expired adds a PICK scan and an EMIT per expired slot. All of
// it is set by one deadline comparator walking the slot table.
// Reset (rst, synchronous) clears the clock, armed bits and control; the
// deadline table is not cleared. A stalled rsp holds the sequencer in EMIT;
// req_ready is high only while the sequencer is idle.
module deadline_timer_queue_top
  import dtq_pkg::*;
#(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_item_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_item_t rsp
);

  // The slot field addresses at most 16 slots
  localparam int SLOTS = (NUM_TIMERS < MAX_SLOTS) ? NUM_TIMERS : MAX_SLOTS;
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [SW-1:0] IDX_LAST = SW'(SLOTS - 1);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for an item
  localparam logic [2:0] S_MARK = 3'd1;  // tick: find and disarm due slots
  localparam logic [2:0] S_MIN  = 3'd2;  // nearest pending deadline
  localparam logic [2:0] S_FIN  = 3'd3;  // time left to that deadline
  localparam logic [2:0] S_PICK = 3'd4;  // earliest remaining due slot
  localparam logic [2:0] S_EMIT = 3'd5;  // hand a result to the output reg

  logic [2:0]       state;
  logic [SW-1:0]    idx;
  logic [CLK_W-1:0] now_ms;
  logic [SLOTS-1:0] armed;
  logic [SLOTS-1:0] due;
  logic [CLK_W-1:0] dl [SLOTS];

  // Latched item context
  logic [1:0]       op_status;
  logic             op_exp;

  // Scan results
  logic [CLK_W-1:0] best;
  logic             any;
  logic [CLK_W-1:0] pbest;
  logic             found;
  logic [SW-1:0]    pick;
  logic [31:0]      rem;
  logic             nonep;

  // Shared comparator: cmp_lt = cmp_a < cmp_b
  logic [CLK_W-1:0] cmp_a;
  logic [CLK_W-1:0] cmp_b;
  logic             cmp_lt;
  logic [CLK_W-1:0] dl_sel;
  logic [CLK_W-1:0] diff;
  logic [SLOTS-1:0] due_rest;
  logic             req_fire;
  logic             slot_ok;
  logic [SW-1:0]    req_idx;
  logic             out_free;

  assign dl_sel   = dl[idx];
  assign req_ready = (state == S_IDLE);
  assign req_fire = req_valid && req_ready;
  assign slot_ok  = (32'(req.slot_id) < SLOTS);
  assign req_idx  = req.slot_id[SW-1:0];
  assign out_free = !rsp_valid || rsp_ready;
  assign diff     = best - now_ms;

  always_comb begin
    case (state)
      S_MARK: begin
        cmp_a = now_ms;
        cmp_b = dl_sel;
      end
      S_MIN: begin
        cmp_a = dl_sel;
        cmp_b = best;
      end
      S_PICK: begin
        cmp_a = dl_sel;
        cmp_b = pbest;
      end
      default: begin
        cmp_a = now_ms;
        cmp_b = best;
      end
    endcase
    cmp_lt = (cmp_a < cmp_b);
  end

  // Due slots left after the one being reported
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      due_rest[i] = due[i] && (SW'(i) != pick);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      now_ms    <= '0;
      armed     <= '0;
      due       <= '0;
      any       <= 1'b0;
      found     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // EMIT refills the output reg itself when it frees up
      if (rsp_valid && rsp_ready && state != S_EMIT) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_fire) begin
            op_status <= ST_OK;
            idx       <= '0;
            any       <= 1'b0;
            state     <= S_MIN;
            if (req.func == FN_ADD && slot_ok) begin
              if (armed[req_idx]) begin
                op_status <= ST_ADD_ARMED;
              end else begin
                armed[req_idx] <= 1'b1;
                dl[req_idx]    <= now_ms + CLK_W'(req.timeout_ms);
              end
            end else if (req.func == FN_DEL && slot_ok) begin
              if (armed[req_idx]) begin
                armed[req_idx] <= 1'b0;
              end else begin
                op_status <= ST_DEL_IDLE;
              end
            end else if (req.func == FN_TICK) begin
              now_ms <= now_ms + CLK_W'(1);
              state  <= S_MARK;
            end
          end
        end
        S_MARK: begin
          // due when deadline <= now
          if (armed[idx] && !cmp_lt) begin
            due[idx]   <= 1'b1;
            armed[idx] <= 1'b0;
          end
          if (idx == IDX_LAST) begin
            idx   <= '0;
            state <= S_MIN;
          end else begin
            idx <= idx + SW'(1);
          end
        end
        S_MIN: begin
          if (armed[idx] && (!any || cmp_lt)) begin
            best <= dl_sel;
            any  <= 1'b1;
          end
          if (idx == IDX_LAST) begin
            state <= S_FIN;
          end else begin
            idx <= idx + SW'(1);
          end
        end
        S_FIN: begin
          nonep <= !any;
          if (!any) begin
            rem <= '1;
          end else if (!cmp_lt) begin
            rem <= '0;  // already due
          end else if (diff[CLK_W-1:32] != '0) begin
            rem <= '1;  // saturate
          end else begin
            rem <= diff[31:0];
          end
          idx   <= '0;
          found <= 1'b0;
          if (due != '0) begin
            op_exp <= 1'b1;
            state  <= S_PICK;
          end else begin
            op_exp <= 1'b0;
            state  <= S_EMIT;
          end
        end
        S_PICK: begin
          // strict less-than keeps the lowest slot on ties
          if (due[idx] && (!found || cmp_lt)) begin
            pbest <= dl_sel;
            pick  <= idx;
            found <= 1'b1;
          end
          if (idx == IDX_LAST) begin
            state <= S_EMIT;
          end else begin
            idx <= idx + SW'(1);
          end
        end
        S_EMIT: begin
          if (out_free) begin
            rsp_valid        <= 1'b1;
            rsp.status       <= op_exp ? ST_OK : op_status;
            rsp.expired      <= op_exp;
            rsp.expired_slot <= op_exp ? SLOT_W'(pick) : '0;
            rsp.none_pending <= nonep;
            rsp.remaining_ms <= rem;
            rsp.last         <= !op_exp || (due_rest == '0);
            idx              <= '0;
            found            <= 1'b0;
            if (op_exp) begin
              due <= due_rest;
            end
            if (op_exp && (due_rest != '0)) begin
              state <= S_PICK;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // Nothing left to report once a new item can be taken
  a_idle_no_due: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> (due == '0))
    else $error("due slots pending while idle");

  // Expiry results always carry ok status
  a_exp_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.expired) |-> (rsp.status == ST_OK))
    else $error("expiry with error status");

  // Empty table reports saturated time left
  a_none_rem: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.none_pending) |-> (rsp.remaining_ms == '1))
    else $error("none pending with finite remaining time");
`endif

endmodule
